/* sv/lqr_obs_pkg.sv */
`timescale 1ns / 1ps

package lqr_obs_pkg;

	localparam int DATA_W = 32;
	localparam int TS_W   = 31;
	localparam int PROD_W = 48;
	localparam int ACC_W  = 50;
	localparam int ADDR_W = 5;
	localparam int STEP_W = 5;

	localparam logic [STEP_W-1:0] LAST_STEP = 5'd17;

	typedef enum logic [2:0] {
		REG_OBS_GAIN_1   = 3'd0,
		REG_OBS_GAIN_2   = 3'd1,
		REG_OBS_GAIN_3   = 3'd2,
		REG_STATE_GAIN_1 = 3'd3,
		REG_STATE_GAIN_2 = 3'd4,
		REG_STATE_GAIN_3 = 3'd5,
		REG_REF_GAIN     = 3'd6,
		REG_SAMPLE_T     = 3'd7
	} reg_idx_t;

	// Multiplier operand A
	typedef enum logic [3:0] {
		A_G1, A_G2, A_G3, A_K1, A_K2, A_K3, A_REF, A_D1, A_D2, A_D3
	} a_src_t;

	// Multiplier operand B
	typedef enum logic [2:0] {
		B_MEAS, B_X1, B_X2, B_X3, B_T, B_KR
	} b_src_t;

	// Plain value added into the accumulator
	typedef enum logic [1:0] {
		V_X1, V_X2, V_X3, V_PREV
	} v_src_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_P,
		ACC_ADD_P,
		ACC_SUB_P,
		ACC_ADD_V,
		ACC_V_P
	} acc_op_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_D1, DST_D2, DST_D3, DST_X1, DST_X2, DST_X3, DST_CMD
	} dst_t;

	typedef struct packed {
		logic    mul_en;
		a_src_t  mul_a;
		b_src_t  mul_b;
		acc_op_t acc_op;
		v_src_t  acc_v;
		dst_t    wb_dst;
		logic    last;
	} ctrl_t;

	// Microprogram. A product issued in one step lands in the product
	// register and is used by the accumulator in a later step; a write-back
	// saturates the accumulator as it stands at the start of the step.
	function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
		ctrl_t cw;
		cw.mul_en = 1'b0;
		cw.mul_a  = A_G1;
		cw.mul_b  = B_MEAS;
		cw.acc_op = ACC_HOLD;
		cw.acc_v  = V_X1;
		cw.wb_dst = DST_NONE;
		cw.last   = 1'b0;
		case (step)
			5'd0: begin
				cw.mul_en = 1'b1; cw.mul_a = A_G1; cw.mul_b = B_MEAS;
			end
			5'd1: begin
				cw.mul_en = 1'b1; cw.mul_a = A_G1; cw.mul_b = B_X1;
				cw.acc_op = ACC_P;
			end
			5'd2: begin
				cw.mul_en = 1'b1; cw.mul_a = A_G2; cw.mul_b = B_MEAS;
				cw.acc_op = ACC_SUB_P;
			end
			5'd3: begin
				cw.acc_op = ACC_ADD_V; cw.acc_v = V_X2;
			end
			5'd4: begin
				cw.mul_en = 1'b1; cw.mul_a = A_G2; cw.mul_b = B_X1;
				cw.acc_op = ACC_P; cw.wb_dst = DST_D1;
			end
			5'd5: begin
				cw.mul_en = 1'b1; cw.mul_a = A_G3; cw.mul_b = B_MEAS;
				cw.acc_op = ACC_SUB_P;
			end
			5'd6: begin
				cw.acc_op = ACC_ADD_V; cw.acc_v = V_X3;
			end
			5'd7: begin
				cw.acc_op = ACC_ADD_V; cw.acc_v = V_PREV;
			end
			5'd8: begin
				cw.mul_en = 1'b1; cw.mul_a = A_G3; cw.mul_b = B_X1;
				cw.acc_op = ACC_P; cw.wb_dst = DST_D2;
			end
			5'd9: begin
				cw.mul_en = 1'b1; cw.mul_a = A_D1; cw.mul_b = B_T;
				cw.acc_op = ACC_SUB_P;
			end
			5'd10: begin
				cw.mul_en = 1'b1; cw.mul_a = A_D2; cw.mul_b = B_T;
				cw.acc_op = ACC_V_P; cw.acc_v = V_X1; cw.wb_dst = DST_D3;
			end
			5'd11: begin
				cw.mul_en = 1'b1; cw.mul_a = A_D3; cw.mul_b = B_T;
				cw.acc_op = ACC_V_P; cw.acc_v = V_X2; cw.wb_dst = DST_X1;
			end
			5'd12: begin
				cw.mul_en = 1'b1; cw.mul_a = A_REF; cw.mul_b = B_KR;
				cw.acc_op = ACC_V_P; cw.acc_v = V_X3; cw.wb_dst = DST_X2;
			end
			5'd13: begin
				cw.mul_en = 1'b1; cw.mul_a = A_K1; cw.mul_b = B_X1;
				cw.acc_op = ACC_P; cw.wb_dst = DST_X3;
			end
			5'd14: begin
				cw.mul_en = 1'b1; cw.mul_a = A_K2; cw.mul_b = B_X2;
				cw.acc_op = ACC_SUB_P;
			end
			5'd15: begin
				cw.mul_en = 1'b1; cw.mul_a = A_K3; cw.mul_b = B_X3;
				cw.acc_op = ACC_SUB_P;
			end
			5'd16: begin
				cw.acc_op = ACC_SUB_P;
			end
			5'd17: begin
				cw.wb_dst = DST_CMD; cw.last = 1'b1;
			end
			default: begin
				cw.last = 1'b1;
			end
		endcase
		return cw;
	endfunction

	// Clamp the accumulator to the signed 32 bit range
	function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic fits;
		fits = (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){1'b0}})
			|| (v[ACC_W-1:DATA_W-1] == {(ACC_W-DATA_W+1){1'b1}});
		if (fits) begin
			return v[DATA_W-1:0];
		end else if (v[ACC_W-1]) begin
			return {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			return {1'b0, {(DATA_W-1){1'b1}}};
		end
	endfunction

endpackage

/* sv/lqr_obs_if.sv */
`timescale 1ns / 1ps

interface lqr_obs_in_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [lqr_obs_pkg::DATA_W-1:0]   reference;
	logic signed [lqr_obs_pkg::DATA_W-1:0]   measurement;

	modport source (output valid, output reference, output measurement, input ready);
	modport sink (input valid, input reference, input measurement, output ready);
endinterface

interface lqr_obs_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [lqr_obs_pkg::DATA_W-1:0]   command;

	modport source (output valid, output command, input ready);
	modport sink (input valid, input command, output ready);
endinterface

/* sv/lqr_observer_state_feedback.sv */
`timescale 1ns / 1ps

// Channel   Dir  Payload                        Handshake
// sample    in   reference, measurement (Q16.16) valid/ready, taken when both high
// drive     out  command (Q16.16, saturated)     valid/ready, taken when both high
// apb       in   eight registers at 4*i, T 31 bit write at psel&penable&pwrite
//
// An accepted item runs an 18 step microprogram that sends every product
// through a single 32x32 MAC; no new item is taken until it finishes.
// The command leaves through an output register, so the next item is taken
// while the last command still waits; the final step holds until that slot
// is free. Reset (arst_n, async, active low) clears registers, observer
// states, the previous command and the sequencer.

module lqr_observer_state_feedback (
	input  logic                                  clk,
	input  logic                                  arst_n,
	lqr_obs_in_if.sink                            sample,
	lqr_obs_out_if.source                         drive,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [lqr_obs_pkg::ADDR_W-1:0]        paddr,
	input  logic [lqr_obs_pkg::DATA_W-1:0]        pwdata,
	output logic [lqr_obs_pkg::DATA_W-1:0]        prdata,
	output logic                                  pready
);

	localparam int DW = lqr_obs_pkg::DATA_W;
	localparam int PW = lqr_obs_pkg::PROD_W;
	localparam int AW = lqr_obs_pkg::ACC_W;
	localparam int TW = lqr_obs_pkg::TS_W;

	// Configuration registers
	logic signed [DW-1:0] og1_q, og2_q, og3_q;
	logic signed [DW-1:0] sg1_q, sg2_q, sg3_q;
	logic signed [DW-1:0] rg_q;
	logic [TW-1:0]        ts_q;

	// Observer state and previous command
	logic signed [DW-1:0] x1_q, x2_q, x3_q, prev_q;

	// Item operands and intermediate derivatives
	logic signed [DW-1:0] ref_q, meas_q;
	logic signed [DW-1:0] d1_q, d2_q, d3_q;

	// Datapath
	logic signed [PW-1:0] p_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] acc_d;
	logic signed [DW-1:0] mul_a, mul_b, acc_v;
	logic signed [2*DW-1:0] prod_rnd;
	logic signed [DW-1:0] sat_val;

	// Sequencer
	logic                                busy_q;
	logic [lqr_obs_pkg::STEP_W-1:0]      step_q;
	lqr_obs_pkg::ctrl_t                  cw;
	logic                                advance;
	logic                                take;

	// Output register
	logic                 out_valid_q;
	logic signed [DW-1:0] cmd_q;

	logic                   cfg_wr;
	lqr_obs_pkg::reg_idx_t  cfg_idx;

	// ---------------------------------------------------------------
	// Configuration port: zero wait states, index from the word address
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = lqr_obs_pkg::reg_idx_t'(paddr[lqr_obs_pkg::ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			og1_q <= '0;
			og2_q <= '0;
			og3_q <= '0;
			sg1_q <= '0;
			sg2_q <= '0;
			sg3_q <= '0;
			rg_q  <= '0;
			ts_q  <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				lqr_obs_pkg::REG_OBS_GAIN_1:   og1_q <= pwdata;
				lqr_obs_pkg::REG_OBS_GAIN_2:   og2_q <= pwdata;
				lqr_obs_pkg::REG_OBS_GAIN_3:   og3_q <= pwdata;
				lqr_obs_pkg::REG_STATE_GAIN_1: sg1_q <= pwdata;
				lqr_obs_pkg::REG_STATE_GAIN_2: sg2_q <= pwdata;
				lqr_obs_pkg::REG_STATE_GAIN_3: sg3_q <= pwdata;
				lqr_obs_pkg::REG_REF_GAIN:     rg_q  <= pwdata;
				lqr_obs_pkg::REG_SAMPLE_T:     ts_q  <= pwdata[TW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			lqr_obs_pkg::REG_OBS_GAIN_1:   prdata = og1_q;
			lqr_obs_pkg::REG_OBS_GAIN_2:   prdata = og2_q;
			lqr_obs_pkg::REG_OBS_GAIN_3:   prdata = og3_q;
			lqr_obs_pkg::REG_STATE_GAIN_1: prdata = sg1_q;
			lqr_obs_pkg::REG_STATE_GAIN_2: prdata = sg2_q;
			lqr_obs_pkg::REG_STATE_GAIN_3: prdata = sg3_q;
			lqr_obs_pkg::REG_REF_GAIN:     prdata = rg_q;
			lqr_obs_pkg::REG_SAMPLE_T:     prdata = {1'b0, ts_q};
			default:                       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: take an item when idle, walk the program, and hold the
	// last step while the previous command still sits in the output slot
	// ---------------------------------------------------------------
	assign sample.ready = !busy_q;
	assign take         = sample.valid && !busy_q;
	assign cw           = lqr_obs_pkg::ctrl_rom(step_q);
	assign advance      = busy_q && !(cw.last && out_valid_q && !drive.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (advance) begin
			if (cw.last) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ref_q  <= sample.reference;
			meas_q <= sample.measurement;
		end
	end

	// ---------------------------------------------------------------
	// Operand selection
	// ---------------------------------------------------------------
	always_comb begin
		case (cw.mul_a)
			lqr_obs_pkg::A_G1:  mul_a = og1_q;
			lqr_obs_pkg::A_G2:  mul_a = og2_q;
			lqr_obs_pkg::A_G3:  mul_a = og3_q;
			lqr_obs_pkg::A_K1:  mul_a = sg1_q;
			lqr_obs_pkg::A_K2:  mul_a = sg2_q;
			lqr_obs_pkg::A_K3:  mul_a = sg3_q;
			lqr_obs_pkg::A_REF: mul_a = ref_q;
			lqr_obs_pkg::A_D1:  mul_a = d1_q;
			lqr_obs_pkg::A_D2:  mul_a = d2_q;
			lqr_obs_pkg::A_D3:  mul_a = d3_q;
			default:            mul_a = '0;
		endcase
	end

	always_comb begin
		case (cw.mul_b)
			lqr_obs_pkg::B_MEAS: mul_b = meas_q;
			lqr_obs_pkg::B_X1:   mul_b = x1_q;
			lqr_obs_pkg::B_X2:   mul_b = x2_q;
			lqr_obs_pkg::B_X3:   mul_b = x3_q;
			lqr_obs_pkg::B_T:    mul_b = {1'b0, ts_q};
			lqr_obs_pkg::B_KR:   mul_b = rg_q;
			default:             mul_b = '0;
		endcase
	end

	always_comb begin
		case (cw.acc_v)
			lqr_obs_pkg::V_X1:   acc_v = x1_q;
			lqr_obs_pkg::V_X2:   acc_v = x2_q;
			lqr_obs_pkg::V_X3:   acc_v = x3_q;
			lqr_obs_pkg::V_PREV: acc_v = prev_q;
			default:             acc_v = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// MAC: round half up to Q16.16, keep the full 48 bit result
	// ---------------------------------------------------------------
	assign prod_rnd = (mul_a * mul_b) + (2*DW)'(32768);

	always_ff @(posedge clk) begin
		if (advance && cw.mul_en) begin
			p_q <= prod_rnd[2*DW-1:16];
		end
	end

	always_comb begin
		case (cw.acc_op)
			lqr_obs_pkg::ACC_P:     acc_d = AW'(p_q);
			lqr_obs_pkg::ACC_ADD_P: acc_d = acc_q + AW'(p_q);
			lqr_obs_pkg::ACC_SUB_P: acc_d = acc_q - AW'(p_q);
			lqr_obs_pkg::ACC_ADD_V: acc_d = acc_q + AW'(acc_v);
			lqr_obs_pkg::ACC_V_P:   acc_d = AW'(acc_v) + AW'(p_q);
			default:                acc_d = acc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_q <= acc_d;
		end
	end

	// ---------------------------------------------------------------
	// Write-back: saturate the accumulator into its destination
	// ---------------------------------------------------------------
	assign sat_val = lqr_obs_pkg::sat32(acc_q);

	always_ff @(posedge clk) begin
		if (advance) begin
			case (cw.wb_dst)
				lqr_obs_pkg::DST_D1: d1_q <= sat_val;
				lqr_obs_pkg::DST_D2: d2_q <= sat_val;
				lqr_obs_pkg::DST_D3: d3_q <= sat_val;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q   <= '0;
			x2_q   <= '0;
			x3_q   <= '0;
			prev_q <= '0;
		end else if (advance) begin
			case (cw.wb_dst)
				lqr_obs_pkg::DST_X1:  x1_q   <= sat_val;
				lqr_obs_pkg::DST_X2:  x2_q   <= sat_val;
				lqr_obs_pkg::DST_X3:  x3_q   <= sat_val;
				lqr_obs_pkg::DST_CMD: prev_q <= sat_val;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Output register: load on the command write-back, else drop on take
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (advance && cw.wb_dst == lqr_obs_pkg::DST_CMD) begin
				out_valid_q <= 1'b1;
			end else if (drive.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && cw.wb_dst == lqr_obs_pkg::DST_CMD) begin
			cmd_q <= sat_val;
		end
	end

	assign drive.valid   = out_valid_q;
	assign drive.command = cmd_q;

`ifndef ASSERT_OFF
	a_take_starts_program: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> (busy_q && step_q == '0))
		else $error("accepted item did not start the program at step zero");

	a_step_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= lqr_obs_pkg::LAST_STEP))
		else $error("step counter ran past the end of the program");

	a_result_from_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && cw.last))
		else $error("command raised outside the final program step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cw.wb_dst == lqr_obs_pkg::DST_CMD) |-> (!out_valid_q || drive.ready))
		else $error("command written over a pending command");
`endif

endmodule
